FILE: hdl/whsp_pkg.sv
// Package for the WAV header stream parser.
// Holds parse phases, result codes, chunk tags and controller types.
// No dependencies.
package whsp_pkg;

    localparam logic [31:0] TAG_RIFF   = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE   = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT    = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA   = 32'h6461_7461;
    localparam logic [31:0] FMT_LEN    = 32'd16;
    localparam logic [4:0]  SKIP_LEN   = 5'd6;
    localparam logic [31:0] RIFF_EXTRA = 32'd8;
    localparam logic [15:0] FMT_PCM    = 16'd1;
    localparam logic [15:0] FMT_FLOAT  = 16'd3;

    localparam int QUO_W = 32;
    localparam int DVS_W = 29;
    localparam int ITER_W = $clog2(QUO_W);

    typedef enum logic [3:0] {
        PH_RIFF  = 4'd0,
        PH_SIZE  = 4'd1,
        PH_WAVE  = 4'd2,
        PH_FHDR  = 4'd3,
        PH_FSKIP = 4'd4,
        PH_FBODY = 4'd5,
        PH_DHDR  = 4'd6,
        PH_DSKIP = 4'd7,
        PH_DATA  = 4'd8,
        PH_DONE  = 4'd9,
        PH_ERR   = 4'd10
    } phase_t;

    typedef enum logic [2:0] {
        ST_HDR   = 3'd0,
        ST_DATA  = 3'd1,
        ST_READY = 3'd2,
        ST_ERR   = 3'd3,
        ST_IGN   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_RIFF    = 3'd1,
        ERR_WAVE    = 3'd2,
        ERR_NO_FMT  = 3'd3,
        ERR_FMT_LEN = 3'd4,
        ERR_FMT_TYP = 3'd5,
        ERR_NO_DATA = 3'd6
    } err_t;

    typedef enum logic {
        CS_RUN = 1'b0,
        CS_DIV = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic step;
        logic div_start;
        logic div_commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_req;
        logic div_done;
    } ctrl_stat_t;

endpackage

FILE: hdl/wav_header_stream_parser.sv
// Top level of the WAV header stream parser.
// Depends on whsp_pkg, whsp_ctrl, whsp_dp and whsp_div.
//
//  channel   handshake             payload
//  input     in_valid / in_ready   in_byte, first_byte
//  output    out_valid / out_ready status, error_code, data_byte, last_data,
//                                  channels, rate_hz, sample_bits, float_fmt,
//                                  data_bytes, frame_count
//
//  One byte per cycle while the output drains and no divide runs; one transaction out per byte in.
//  The result for the last byte of the data chunk header waits: the frame count
//  runs through a 32-step restoring divider before its result is shown.
//  Reset is asynchronous and clears all parse state at once; no clearing pass.
//  A byte is taken while no divide runs and the output register is empty or drained that cycle.
module wav_header_stream_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        first_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [2:0]  error_code,
    output logic [7:0]  data_byte,
    output logic        last_data,
    output logic [15:0] channels,
    output logic [31:0] rate_hz,
    output logic [15:0] sample_bits,
    output logic        float_fmt,
    output logic [31:0] data_bytes,
    output logic [31:0] frame_count
);
    import whsp_pkg::*;

    ctrl_cmd_t        cmd;
    ctrl_stat_t       stat;
    logic             div_req;
    logic             div_done;
    logic [QUO_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
    logic [QUO_W-1:0] quotient;
    status_t          status_int;
    err_t             err_int;

    assign stat.div_req  = div_req;
    assign stat.div_done = div_done;

    whsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    whsp_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_byte     (in_byte),
        .first_byte  (first_byte),
        .quotient    (quotient),
        .div_req     (div_req),
        .dividend    (dividend),
        .divisor     (divisor),
        .status      (status_int),
        .error_code  (err_int),
        .data_byte   (data_byte),
        .last_data   (last_data),
        .channels    (channels),
        .rate_hz     (rate_hz),
        .sample_bits (sample_bits),
        .float_fmt   (float_fmt),
        .data_bytes  (data_bytes),
        .frame_count (frame_count)
    );

    whsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign status     = status_int;
    assign error_code = err_int;

endmodule

FILE: hdl/whsp_div.sv
// Restoring divider for the frame count, one quotient bit per cycle.
// Depends on whsp_pkg.
module whsp_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [whsp_pkg::QUO_W-1:0] dividend,
    input  logic [whsp_pkg::DVS_W-1:0] divisor,
    output logic                       done,
    output logic [whsp_pkg::QUO_W-1:0] quotient
);
    import whsp_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (iter_reg == ITER_W'(QUO_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(QUO_W - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
            rem_reg <= fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = (dvs_reg == '0) ? '0 : quo_reg;

endmodule

FILE: hdl/whsp_ctrl.sv
// Transaction sequencer: input and output handshakes, divider start and commit.
// Depends on whsp_pkg.
module whsp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  whsp_pkg::ctrl_stat_t   stat,
    output whsp_pkg::ctrl_cmd_t    cmd
);
    import whsp_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        accept;

    assign in_ready  = (state_reg == CS_RUN) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_RUN:
                if (accept && stat.div_req)
                    state_next = CS_DIV;
            CS_DIV:
                if (stat.div_done)
                    state_next = CS_RUN;
            default:
                state_next = CS_RUN;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            CS_RUN:
            begin
                cmd.step      = accept;
                cmd.div_start = accept && stat.div_req;
                if (accept && !stat.div_req)
                    out_valid_next = 1'b1;
            end
            CS_DIV:
            begin
                cmd.div_commit = stat.div_done;
                if (stat.div_done)
                    out_valid_next = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == CS_DIV |-> !in_ready)
        else $error("input taken while dividing");

    a_start_enters_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> state_reg == CS_DIV && !out_valid_reg)
        else $error("divider start did not enter divide state");

    a_commit_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_commit |-> state_reg == CS_DIV)
        else $error("commit outside divide state");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_commit |=> out_valid_reg && state_reg == CS_RUN)
        else $error("committed result not shown");

endmodule

FILE: hdl/whsp_dp.sv
// Parser datapath: chunk walk, field capture and the result register.
// Depends on whsp_pkg.
module whsp_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  whsp_pkg::ctrl_cmd_t        cmd,
    input  logic [7:0]                 in_byte,
    input  logic                       first_byte,
    input  logic [whsp_pkg::QUO_W-1:0] quotient,
    output logic                       div_req,
    output logic [whsp_pkg::QUO_W-1:0] dividend,
    output logic [whsp_pkg::DVS_W-1:0] divisor,
    output whsp_pkg::status_t          status,
    output whsp_pkg::err_t             error_code,
    output logic [7:0]                 data_byte,
    output logic                       last_data,
    output logic [15:0]                channels,
    output logic [31:0]                rate_hz,
    output logic [15:0]                sample_bits,
    output logic                       float_fmt,
    output logic [31:0]                data_bytes,
    output logic [31:0]                frame_count
);
    import whsp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] rend_reg, rend_next;
    logic [31:0] tag_reg, tag_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [15:0] fmt_reg, fmt_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] depth_reg, depth_next;
    logic [31:0] dsize_reg, dsize_next;
    logic [31:0] frame_reg, frame_next;

    status_t     st_next;
    err_t        err_next;
    logic [7:0]  dbyte_next;
    logic        last_next;
    logic [31:0] product;

    status_t     status_reg;
    err_t        err_reg;
    logic [7:0]  dbyte_reg;
    logic        last_reg;
    logic [15:0] ochan_reg;
    logic [31:0] orate_reg;
    logic [15:0] odepth_reg;
    logic        ofloat_reg;
    logic [31:0] odsize_reg;
    logic [31:0] oframe_reg;

    always_comb
    begin
        logic [4:0]  n;
        logic [2:0]  hn;
        logic [31:0] target;
        logic        is_fhdr;
        logic        fmt_bad;

        phase_next = first_byte ? PH_RIFF : phase_reg;
        pos_next   = first_byte ? '0 : pos_reg;
        rend_next  = first_byte ? '0 : rend_reg;
        tag_next   = first_byte ? '0 : tag_reg;
        cnt_next   = first_byte ? '0 : cnt_reg;
        rem_next   = first_byte ? '0 : rem_reg;
        fmt_next   = first_byte ? '0 : fmt_reg;
        chan_next  = first_byte ? '0 : chan_reg;
        rate_next  = first_byte ? '0 : rate_reg;
        depth_next = first_byte ? '0 : depth_reg;
        dsize_next = first_byte ? '0 : dsize_reg;
        frame_next = first_byte ? '0 : frame_reg;
        st_next    = ST_HDR;
        err_next   = ERR_NONE;
        dbyte_next = '0;
        last_next  = 1'b0;
        div_req    = 1'b0;
        n          = cnt_next;
        hn         = cnt_next[2:0];
        is_fhdr    = (phase_next == PH_FHDR);
        target     = is_fhdr ? TAG_FMT : TAG_DATA;
        fmt_bad    = 1'b0;

        case (phase_next)
            PH_RIFF, PH_WAVE:
            begin
                tag_next = {tag_next[23:0], in_byte};
                if (n < 5'd3)
                    cnt_next = n + 5'd1;
                else
                begin
                    cnt_next = '0;
                    if (phase_next == PH_RIFF)
                    begin
                        if (tag_next != TAG_RIFF)
                        begin
                            phase_next = PH_ERR;
                            st_next    = ST_ERR;
                            err_next   = ERR_RIFF;
                        end
                        else
                            phase_next = PH_SIZE;
                    end
                    else
                    begin
                        if (tag_next != TAG_WAVE)
                        begin
                            phase_next = PH_ERR;
                            st_next    = ST_ERR;
                            err_next   = ERR_WAVE;
                        end
                        else
                            phase_next = PH_FHDR;
                    end
                end
            end
            PH_SIZE:
            begin
                if (n == 5'd0)
                    rend_next = '0;
                rend_next = rend_next | ({24'd0, in_byte} << {n[1:0], 3'b000});
                if (n < 5'd3)
                    cnt_next = n + 5'd1;
                else
                begin
                    cnt_next   = '0;
                    rend_next  = rend_next + RIFF_EXTRA;
                    phase_next = PH_WAVE;
                end
            end
            PH_FHDR, PH_DHDR:
            begin
                if (hn == 3'd0 && pos_next >= rend_next)
                begin
                    phase_next = PH_ERR;
                    st_next    = ST_ERR;
                    err_next   = is_fhdr ? ERR_NO_FMT : ERR_NO_DATA;
                end
                else
                begin
                    if (hn < 3'd4)
                    begin
                        tag_next = {tag_next[23:0], in_byte};
                        if (hn == 3'd0)
                            rem_next = '0;
                    end
                    else
                        rem_next = rem_next | ({24'd0, in_byte} << {hn[1:0], 3'b000});
                    if (hn < 3'd7)
                        cnt_next = {2'b00, hn + 3'd1};
                    else
                    begin
                        cnt_next = '0;
                        if (tag_next == target)
                        begin
                            if (is_fhdr)
                            begin
                                if (rem_next != FMT_LEN)
                                begin
                                    phase_next = PH_ERR;
                                    st_next    = ST_ERR;
                                    err_next   = ERR_FMT_LEN;
                                end
                                else
                                    phase_next = PH_FBODY;
                            end
                            else
                            begin
                                div_req    = 1'b1;
                                dsize_next = rem_next;
                                st_next    = ST_READY;
                                phase_next = (rem_next == '0) ? PH_DONE : PH_DATA;
                            end
                        end
                        else if (rem_next != '0)
                            phase_next = is_fhdr ? PH_FSKIP : PH_DSKIP;
                    end
                end
            end
            PH_FSKIP, PH_DSKIP:
            begin
                rem_next = rem_next - 32'd1;
                if (rem_next == '0)
                begin
                    phase_next = (phase_next == PH_FSKIP) ? PH_FHDR : PH_DHDR;
                    cnt_next   = '0;
                end
            end
            PH_FBODY:
            begin
                if (n == 5'd0)
                    fmt_next = {8'd0, in_byte};
                else if (n == 5'd1)
                begin
                    fmt_next = fmt_next | {in_byte, 8'd0};
                    if (fmt_next != FMT_PCM && fmt_next != FMT_FLOAT)
                    begin
                        fmt_bad    = 1'b1;
                        phase_next = PH_ERR;
                        st_next    = ST_ERR;
                        err_next   = ERR_FMT_TYP;
                        cnt_next   = '0;
                    end
                end
                else if (n == 5'd2)
                    chan_next = {8'd0, in_byte};
                else if (n == 5'd3)
                    chan_next = chan_next | {in_byte, 8'd0};
                else if (n < 5'd8)
                begin
                    if (n == 5'd4)
                        rate_next = '0;
                    rate_next = rate_next | ({24'd0, in_byte} << {n[1:0], 3'b000});
                end
                else if (n < 5'd8 + SKIP_LEN)
                    rate_next = rate_next;
                else if (n == 5'd8 + SKIP_LEN)
                    depth_next = {8'd0, in_byte};
                else
                    depth_next = depth_next | {in_byte, 8'd0};
                if (!fmt_bad)
                begin
                    if (n < 5'(FMT_LEN - 32'd1))
                        cnt_next = n + 5'd1;
                    else
                    begin
                        cnt_next   = '0;
                        phase_next = PH_DHDR;
                    end
                end
            end
            PH_DATA:
            begin
                st_next    = ST_DATA;
                dbyte_next = in_byte;
                rem_next   = rem_next - 32'd1;
                if (rem_next == '0)
                begin
                    last_next  = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
                st_next = ST_IGN;
            end
        endcase
        pos_next = pos_next + 32'd1;
    end

    assign product  = chan_reg * depth_reg;
    assign divisor  = product[31:3];
    assign dividend = dsize_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RIFF;
            pos_reg   <= '0;
            rend_reg  <= '0;
            tag_reg   <= '0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            fmt_reg   <= '0;
            chan_reg  <= '0;
            rate_reg  <= '0;
            depth_reg <= '0;
            dsize_reg <= '0;
            frame_reg <= '0;
        end
        else if (cmd.step)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            rend_reg  <= rend_next;
            tag_reg   <= tag_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            fmt_reg   <= fmt_next;
            chan_reg  <= chan_next;
            rate_reg  <= rate_next;
            depth_reg <= depth_next;
            dsize_reg <= dsize_next;
            frame_reg <= frame_next;
        end
        else if (cmd.div_commit)
            frame_reg <= quotient;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            status_reg <= st_next;
            err_reg    <= err_next;
            dbyte_reg  <= dbyte_next;
            last_reg   <= last_next;
            ochan_reg  <= chan_next;
            orate_reg  <= rate_next;
            odepth_reg <= depth_next;
            ofloat_reg <= (fmt_next == FMT_FLOAT);
            odsize_reg <= dsize_next;
            oframe_reg <= frame_next;
        end
        else if (cmd.div_commit)
            oframe_reg <= quotient;
    end

    assign status      = status_reg;
    assign error_code  = err_reg;
    assign data_byte   = dbyte_reg;
    assign last_data   = last_reg;
    assign channels    = ochan_reg;
    assign rate_hz     = orate_reg;
    assign sample_bits = odepth_reg;
    assign float_fmt   = ofloat_reg;
    assign data_bytes  = odsize_reg;
    assign frame_count = oframe_reg;

endmodule
